>>> design/hswr_pkg.sv
// Package for the handle stack with removal: payload structs, operation and
// status codes, and default sizes. No dependencies.
`default_nettype none

package hswr_pkg;

  // Default sizes handed to the top level
  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned DATA_BITS_DEF   = 32;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  // Operation codes
  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_TOP    = 2'd2;
  localparam logic [1:0] FUNC_REMOVE = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] push_data;
    logic [15:0] remove_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] new_handle;
    logic [31:0] top_data;
    logic [4:0]  entry_count;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/handle_stack_with_removal.sv
// Handle stack with removal: LIFO of data words tagged with handles, with
// remove-by-handle done by a scan and close-up sequencer. Uses hswr_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------
//   in_     | input     | in_valid/in_ready  | hswr_pkg::in_item_t
//   out_    | output    | out_valid/out_ready| hswr_pkg::out_item_t
//
// Push and an empty-stack error go straight to the finish state; pop and top
// query first read the top entry. Remove scans and then closes up: one
// single-port read and one handle comparator walk the stack memory one entry
// per cycle from the top, then the close-up moves one entry per cycle.
// Reset (synchronous, rst_n low) empties the stack and zeroes the handle
// counter; the memory needs no clearing. A stalled result sits in the output
// register while the next item is taken and worked on.
`default_nettype none

module handle_stack_with_removal #(
  parameter int unsigned DEPTH       = hswr_pkg::DEPTH_DEF,
  parameter int unsigned DATA_BITS   = hswr_pkg::DATA_BITS_DEF,
  parameter int unsigned HANDLE_BITS = hswr_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hswr_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hswr_pkg::out_item_t      out_data
);

  localparam int unsigned IDX = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [DATA_BITS-1:0]   word;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  // Stack memory: one write port, one registered read port
  entry_t mem [DEPTH];
  entry_t rd_q_r;
  logic [IDX-1:0] rd_addr;
  logic           wr_en;
  logic [IDX-1:0] wr_addr;
  entry_t         wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
  end

  // Sequencer state and registers
  state_t                 state_r, state_nxt;
  logic [CNT-1:0]         fill_r, fill_nxt;
  logic [HANDLE_BITS-1:0] next_r, next_nxt;
  logic [HANDLE_BITS-1:0] want_r, want_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [IDX-1:0]         scan_idx_r, scan_idx_nxt;
  logic [IDX-1:0]         shift_idx_r, shift_idx_nxt;
  logic [1:0]             res_status_r, res_status_nxt;
  logic [15:0]            res_handle_r, res_handle_nxt;
  logic [31:0]            res_top_r, res_top_nxt;
  logic                   out_valid_r, out_valid_nxt;
  hswr_pkg::out_item_t    out_data_r, out_data_nxt;

  logic [IDX-1:0] top_idx;
  logic           full;

  assign top_idx = IDX'(fill_r - CNT'(1));
  assign full    = (fill_r == CNT'(DEPTH));

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    next_nxt       = next_r;
    want_nxt       = want_r;
    op_nxt         = op_r;
    scan_idx_nxt   = scan_idx_r;
    shift_idx_nxt  = shift_idx_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_top_nxt    = res_top_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data.func;
          want_nxt       = HANDLE_BITS'(in_data.remove_handle);
          res_status_nxt = hswr_pkg::ST_OK;
          res_handle_nxt = '0;
          res_top_nxt    = '0;
          if (in_data.func == hswr_pkg::FUNC_PUSH) begin
            if (full) begin
              res_status_nxt = hswr_pkg::ST_FULL;
            end else begin
              wr_en          = 1'b1;
              wr_addr        = IDX'(fill_r);
              wr_data        = '{handle: next_r, word: DATA_BITS'(in_data.push_data)};
              res_handle_nxt = 16'(next_r);
              fill_nxt       = fill_r + CNT'(1);
              next_nxt       = next_r + HANDLE_BITS'(1);
            end
            state_nxt = S_FINISH;
          end else if (fill_r == '0) begin
            res_status_nxt = hswr_pkg::ST_EMPTY;
            state_nxt      = S_FINISH;
          end else begin
            rd_addr      = top_idx;
            scan_idx_nxt = top_idx;
            state_nxt    = (in_data.func == hswr_pkg::FUNC_REMOVE) ? S_SCAN : S_READ;
          end
        end
      end

      // top entry is in the read register: pop or top query
      S_READ: begin
        if (op_r == hswr_pkg::FUNC_POP) begin
          next_nxt = rd_q_r.handle;
          fill_nxt = fill_r - CNT'(1);
        end else begin
          res_top_nxt = 32'(rd_q_r.word);
        end
        state_nxt = S_FINISH;
      end

      // compare one handle per cycle, walking down from the top
      S_SCAN: begin
        if (rd_q_r.handle == want_r) begin
          next_nxt = rd_q_r.handle;
          if (scan_idx_r == top_idx) begin
            fill_nxt  = fill_r - CNT'(1);
            state_nxt = S_FINISH;
          end else begin
            rd_addr       = scan_idx_r + IDX'(1);
            shift_idx_nxt = scan_idx_r;
            state_nxt     = S_SHIFT;
          end
        end else if (scan_idx_r == '0) begin
          res_status_nxt = hswr_pkg::ST_NOT_FOUND;
          state_nxt      = S_FINISH;
        end else begin
          rd_addr      = scan_idx_r - IDX'(1);
          scan_idx_nxt = scan_idx_r - IDX'(1);
        end
      end

      // close up: entry above the hole moves down one per cycle
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = shift_idx_r;
        wr_data = rd_q_r;
        if ((CNT'(shift_idx_r) + CNT'(2)) < fill_r) begin
          rd_addr       = IDX'(CNT'(shift_idx_r) + CNT'(2));
          shift_idx_nxt = shift_idx_r + IDX'(1);
        end else begin
          fill_nxt  = fill_r - CNT'(1);
          state_nxt = S_FINISH;
        end
      end

      // load the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.status      = res_status_r;
          out_data_nxt.new_handle  = res_handle_r;
          out_data_nxt.top_data    = res_top_r;
          out_data_nxt.entry_count = 5'(fill_r);
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      next_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
    end
    want_r       <= want_nxt;
    op_r         <= op_nxt;
    scan_idx_r   <= scan_idx_nxt;
    shift_idx_r  <= shift_idx_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_top_r    <= res_top_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> design/hswr_checker.sv
// Port-level checks for the handle stack with removal, bound to the top
// level. Uses hswr_pkg for the payload types and status codes.
`default_nettype none

module hswr_checker #(
  parameter int unsigned DEPTH = hswr_pkg::DEPTH_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire hswr_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // empty status means nothing is held
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == hswr_pkg::ST_EMPTY) |-> out_data.entry_count == 5'd0)
    else $error("empty status with entries held");

  // a refused push hands out no handle and leaves the stack full
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == hswr_pkg::ST_FULL) |->
      (out_data.new_handle == 16'd0) && (out_data.entry_count == 5'(DEPTH)))
    else $error("full status inconsistent");

  // count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.entry_count) <= 32'(DEPTH)))
    else $error("entry count beyond depth");

endmodule

bind handle_stack_with_removal hswr_checker #(.DEPTH(DEPTH)) u_hswr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
